// ===== sv/spicb_pkg.sv =====
`timescale 1ns / 1ps

package spicb_pkg;

	typedef enum logic [1:0] {
		REQ_SEL_FALL = 2'd0,
		REQ_SEL_RISE = 2'd1,
		REQ_TICK     = 2'd2,
		REQ_RSVD     = 2'd3
	} req_type_t;

	typedef enum logic [2:0] {
		MODE_IDLE = 3'd0,
		MODE_READ = 3'd1,
		MODE_GEN0 = 3'd2,
		MODE_GEN1 = 3'd3,
		MODE_I2C  = 3'd4,
		MODE_PWMA = 3'd5,
		MODE_PWMB = 3'd6
	} mode_t;

	typedef enum logic [0:0] {
		CFG_SLEW_STEP      = 1'b0,
		CFG_SHUTDOWN_TICKS = 1'b1
	} cfg_reg_t;

	localparam logic [15:0] CMD_READ_ENC = 16'h0010;
	localparam logic [15:0] CMD_GEN0     = 16'h0020;
	localparam logic [15:0] CMD_GEN1     = 16'h0040;
	localparam logic [15:0] CMD_I2C      = 16'h0080;
	localparam logic [15:0] CMD_PWMA     = 16'h0100;
	localparam logic [15:0] CMD_PWMB     = 16'h0200;
	localparam logic [15:0] STATUS_IDLE  = 16'h0001;

	localparam logic [15:0] SLEW_STEP_RST      = 16'd50;
	localparam logic [15:0] SHUTDOWN_TICKS_RST = 16'd2000;
	localparam logic [15:0] LOSS_MAX           = 16'hFFFF;
	localparam logic [1:0]  READ_LAST          = 2'd2;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [15:0] rx_word;
		logic [15:0] enc_a;
		logic [15:0] enc_b;
		logic [15:0] enc_c;
		logic        power_lost;
	} in_item_t;

	typedef struct packed {
		logic        tx_load;
		logic        tx_front;
		logic [15:0] tx_word;
		logic        gen_write;
		logic        gen_channel;
		logic [15:0] gen_word;
		logic        i2c_write;
		logic [7:0]  i2c_address;
		logic [7:0]  i2c_byte;
		logic [15:0] pwm_a_out;
		logic [15:0] pwm_b_out;
		logic        shutdown_req;
	} out_item_t;

	// trailing encoder words of a read command, appended after the first result
	typedef struct packed {
		logic [1:0]  extra;
		logic [15:0] word_b;
		logic [15:0] word_c;
	} burst_t;

endpackage

// ===== sv/spicb_core.sv =====
`timescale 1ns / 1ps

module spicb_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [0:0]            cfg_index,
	input  logic [15:0]           cfg_data,
	input  logic                  go,
	input  spicb_pkg::in_item_t   item,
	output spicb_pkg::out_item_t  res,
	output spicb_pkg::burst_t     burst
);

	logic [15:0]      slew_step_q;
	logic [15:0]      shutdown_ticks_q;
	spicb_pkg::mode_t mode_q, mode_nx;
	logic [1:0]       read_count_q, read_count_nx;
	logic [15:0]      pwm_a_target_q, pwm_a_target_nx;
	logic [15:0]      pwm_b_target_q, pwm_b_target_nx;
	logic [15:0]      pwm_a_now_q, pwm_a_now_nx;
	logic [15:0]      pwm_b_now_q, pwm_b_now_nx;
	logic [15:0]      loss_count_q, loss_count_nx;
	logic [15:0]      loss_inc;
	logic [15:0]      slew_a, slew_b;

	function automatic logic [15:0] slew(input logic [15:0] now, input logic [15:0] target,
		input logic [15:0] step);
		logic [15:0] r;
		if (target > now) begin
			r = ((target - now) > step) ? now + step : target;
		end else begin
			r = ((now - target) > step) ? now - step : target;
		end
		return r;
	endfunction

	assign slew_a   = slew(pwm_a_now_q, pwm_a_target_q, slew_step_q);
	assign slew_b   = slew(pwm_b_now_q, pwm_b_target_q, slew_step_q);
	assign loss_inc = loss_count_q + 16'd1;

	always_comb begin
		mode_nx         = mode_q;
		read_count_nx   = read_count_q;
		pwm_a_target_nx = pwm_a_target_q;
		pwm_b_target_nx = pwm_b_target_q;
		pwm_a_now_nx    = pwm_a_now_q;
		pwm_b_now_nx    = pwm_b_now_q;
		loss_count_nx   = loss_count_q;
		res             = '0;
		burst           = '0;
		burst.word_b    = item.enc_b;
		burst.word_c    = item.enc_c;

		unique case (spicb_pkg::req_type_t'(item.req_type))
			spicb_pkg::REQ_SEL_FALL: begin
				res.tx_front = 1'b1;
				res.tx_load  = 1'b1;
				unique case (mode_q)
					spicb_pkg::MODE_IDLE: res.tx_word = spicb_pkg::STATUS_IDLE;
					spicb_pkg::MODE_GEN0: res.tx_word = spicb_pkg::CMD_GEN0;
					spicb_pkg::MODE_GEN1: res.tx_word = spicb_pkg::CMD_GEN1;
					spicb_pkg::MODE_I2C:  res.tx_word = spicb_pkg::CMD_I2C;
					spicb_pkg::MODE_PWMA: res.tx_word = spicb_pkg::CMD_PWMA;
					spicb_pkg::MODE_PWMB: res.tx_word = spicb_pkg::CMD_PWMB;
					default: begin
						res.tx_front = 1'b0;
						res.tx_load  = 1'b0;
					end
				endcase
			end
			spicb_pkg::REQ_SEL_RISE: begin
				unique case (mode_q)
					spicb_pkg::MODE_IDLE: begin
						read_count_nx = '0;
						priority if (item.rx_word == spicb_pkg::CMD_READ_ENC) begin
							mode_nx      = spicb_pkg::MODE_READ;
							res.tx_load  = 1'b1;
							res.tx_front = 1'b1;
							res.tx_word  = item.enc_a;
							burst.extra  = 2'd2;
						end else if (item.rx_word == spicb_pkg::CMD_GEN0) begin
							mode_nx = spicb_pkg::MODE_GEN0;
						end else if (item.rx_word == spicb_pkg::CMD_GEN1) begin
							mode_nx = spicb_pkg::MODE_GEN1;
						end else if (item.rx_word == spicb_pkg::CMD_I2C) begin
							mode_nx = spicb_pkg::MODE_I2C;
						end else if (item.rx_word == spicb_pkg::CMD_PWMA) begin
							mode_nx = spicb_pkg::MODE_PWMA;
						end else if (item.rx_word == spicb_pkg::CMD_PWMB) begin
							mode_nx = spicb_pkg::MODE_PWMB;
						end
					end
					spicb_pkg::MODE_READ: begin
						if (read_count_q < spicb_pkg::READ_LAST) begin
							read_count_nx = read_count_q + 2'd1;
						end else begin
							mode_nx       = spicb_pkg::MODE_IDLE;
							read_count_nx = '0;
						end
					end
					spicb_pkg::MODE_GEN0, spicb_pkg::MODE_GEN1: begin
						res.gen_write   = 1'b1;
						res.gen_channel = (mode_q == spicb_pkg::MODE_GEN1);
						res.gen_word    = item.rx_word;
						mode_nx         = spicb_pkg::MODE_IDLE;
					end
					spicb_pkg::MODE_I2C: begin
						res.i2c_write   = 1'b1;
						res.i2c_address = item.rx_word[15:8];
						res.i2c_byte    = item.rx_word[7:0];
						mode_nx         = spicb_pkg::MODE_IDLE;
					end
					spicb_pkg::MODE_PWMA: begin
						pwm_a_target_nx = item.rx_word;
						mode_nx         = spicb_pkg::MODE_IDLE;
					end
					spicb_pkg::MODE_PWMB: begin
						pwm_b_target_nx = item.rx_word;
						mode_nx         = spicb_pkg::MODE_IDLE;
					end
					default: mode_nx = spicb_pkg::MODE_IDLE;
				endcase
			end
			spicb_pkg::REQ_TICK: begin
				pwm_a_now_nx = slew_a;
				pwm_b_now_nx = slew_b;
				if (item.power_lost) begin
					// saturate, so shutdown fires only on first reaching the threshold
					if (loss_count_q != spicb_pkg::LOSS_MAX) begin
						loss_count_nx    = loss_inc;
						res.shutdown_req = (loss_inc == shutdown_ticks_q);
					end
				end else begin
					loss_count_nx = '0;
				end
			end
			default: ;
		endcase

		res.pwm_a_out = pwm_a_now_nx;
		res.pwm_b_out = pwm_b_now_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slew_step_q      <= spicb_pkg::SLEW_STEP_RST;
			shutdown_ticks_q <= spicb_pkg::SHUTDOWN_TICKS_RST;
		end else if (cfg_we) begin
			if (cfg_index == spicb_pkg::CFG_SLEW_STEP) begin
				slew_step_q <= cfg_data;
			end else begin
				shutdown_ticks_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= spicb_pkg::MODE_IDLE;
			read_count_q   <= '0;
			pwm_a_target_q <= '0;
			pwm_b_target_q <= '0;
			pwm_a_now_q    <= '0;
			pwm_b_now_q    <= '0;
			loss_count_q   <= '0;
		end else if (go) begin
			mode_q         <= mode_nx;
			read_count_q   <= read_count_nx;
			pwm_a_target_q <= pwm_a_target_nx;
			pwm_b_target_q <= pwm_b_target_nx;
			pwm_a_now_q    <= pwm_a_now_nx;
			pwm_b_now_q    <= pwm_b_now_nx;
			loss_count_q   <= loss_count_nx;
		end
	end

endmodule

// ===== sv/spicb_outreg.sv =====
`timescale 1ns / 1ps

module spicb_outreg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  spicb_pkg::out_item_t  first,
	input  spicb_pkg::burst_t     burst,
	input  logic                  res_stall,
	output logic                  res_valid,
	output spicb_pkg::out_item_t  res,
	output logic                  free
);

	logic                 valid_q;
	logic [1:0]           left_q;
	logic [15:0]          next_q;
	logic [15:0]          last_q;
	spicb_pkg::out_item_t res_q;
	logic                 take;

	assign take      = valid_q && !res_stall;
	assign free      = !valid_q || (take && (left_q == 2'd0));
	assign res_valid = valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			left_q  <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			left_q  <= burst.extra;
		end else if (take) begin
			if (left_q != 2'd0) begin
				left_q <= left_q - 2'd1;
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	// payload: load a fresh result, or shift in the next queued encoder word
	always_ff @(posedge clk) begin
		if (load) begin
			res_q  <= first;
			next_q <= burst.word_b;
			last_q <= burst.word_c;
		end else if (take && (left_q != 2'd0)) begin
			res_q.tx_front <= 1'b0;
			res_q.tx_word  <= next_q;
			next_q         <= last_q;
		end
	end

endmodule

// ===== sv/spi_command_bridge_slew_limited.sv =====
`timescale 1ns / 1ps

// channel | handshake              | payload
// req     | req_valid / req_stall  | spicb_pkg::in_item_t
// res     | res_valid / res_stall  | spicb_pkg::out_item_t
// cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One input item per cycle while req_stall is low; an encoder read command
// occupies the result register for three results, one per transmit word,
// holding off new items meanwhile. Items pass input register, then result register.
// arst_n clears mode, counters, PWM state and registers to their defaults.
// A stalled result holds; the input register still takes one more item.
module spi_command_bridge_slew_limited (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  spicb_pkg::in_item_t   req,
	output logic                  res_valid,
	input  logic                  res_stall,
	output spicb_pkg::out_item_t  res,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [0:0]            cfg_index,
	input  logic [15:0]           cfg_data
);

	logic                 valid_s1;
	spicb_pkg::in_item_t  item_s1;
	logic                 adv;
	logic                 free;
	spicb_pkg::out_item_t first;
	spicb_pkg::burst_t    burst;

	assign cfg_ready = 1'b1;
	assign adv       = valid_s1 && free;
	assign req_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (req_valid && !req_stall) || (valid_s1 && !adv);
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			item_s1 <= req;
		end
	end

	spicb_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.go        (adv),
		.item      (item_s1),
		.res       (first),
		.burst     (burst)
	);

	spicb_outreg u_outreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv),
		.first     (first),
		.burst     (burst),
		.res_stall (res_stall),
		.res_valid (res_valid),
		.res       (res),
		.free      (free)
	);

	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> $onehot0({res.tx_load, res.gen_write, res.i2c_write, res.shutdown_req}))
		else $error("result carries more than one request");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	a_adv_fills_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> res_valid)
		else $error("advanced item produced no result");

endmodule

// ===== tb/spicb_bridge_checker.sv =====
`timescale 1ns / 1ps

module spicb_bridge_checker
	import spicb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_stall,
	input  in_item_t    req,
	input  logic        res_valid,
	input  logic        res_stall,
	input  out_item_t   res,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          pending
);

	logic [15:0] slew_step      = SLEW_STEP_RST;
	logic [15:0] shutdown_ticks = SHUTDOWN_TICKS_RST;

	mode_t       mode_q   = MODE_IDLE;
	logic [1:0]  read_cnt = '0;
	logic [15:0] tgt_a    = '0;
	logic [15:0] tgt_b    = '0;
	logic [15:0] pwm_a    = '0;
	logic [15:0] pwm_b    = '0;
	logic [15:0] loss_cnt = '0;

	out_item_t expected_results[$];

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	function automatic logic [15:0] slew_toward(logic [15:0] now, logic [15:0] target,
			logic [15:0] step);
		if (target > now) begin
			return (target - now > step) ? now + step : target;
		end
		return (now - target > step) ? now - step : target;
	endfunction

	// unused fields stay zero, PWM fields always carry the current values
	function automatic out_item_t quiet_result();
		out_item_t r;
		r = '0;
		r.pwm_a_out = pwm_a;
		r.pwm_b_out = pwm_b;
		return r;
	endfunction

	task automatic predict_bridge(in_item_t it);
		out_item_t r;
		logic      fire;
		case (it.req_type)
			REQ_SEL_FALL: begin
				r = quiet_result();
				r.tx_load  = 1'b1;
				r.tx_front = 1'b1;
				case (mode_q)
					MODE_IDLE: r.tx_word = STATUS_IDLE;
					MODE_GEN0: r.tx_word = CMD_GEN0;
					MODE_GEN1: r.tx_word = CMD_GEN1;
					MODE_I2C:  r.tx_word = CMD_I2C;
					MODE_PWMA: r.tx_word = CMD_PWMA;
					MODE_PWMB: r.tx_word = CMD_PWMB;
					default: begin
						r.tx_load  = 1'b0;
						r.tx_front = 1'b0;
					end
				endcase
			end
			REQ_SEL_RISE: begin
				r = quiet_result();
				case (mode_q)
					MODE_IDLE: begin
						read_cnt = '0;
						case (it.rx_word)
							CMD_READ_ENC: begin
								mode_q     = MODE_READ;
								r.tx_load  = 1'b1;
								r.tx_front = 1'b1;
								r.tx_word  = it.enc_a;
								expected_results.push_back(r);
								r.tx_front = 1'b0;
								r.tx_word  = it.enc_b;
								expected_results.push_back(r);
								r.tx_word  = it.enc_c;
							end
							CMD_GEN0: mode_q = MODE_GEN0;
							CMD_GEN1: mode_q = MODE_GEN1;
							CMD_I2C:  mode_q = MODE_I2C;
							CMD_PWMA: mode_q = MODE_PWMA;
							CMD_PWMB: mode_q = MODE_PWMB;
							default: ;
						endcase
					end
					MODE_READ: begin
						if (read_cnt < READ_LAST) begin
							read_cnt = read_cnt + 2'd1;
						end else begin
							mode_q   = MODE_IDLE;
							read_cnt = '0;
						end
					end
					MODE_GEN0, MODE_GEN1: begin
						r.gen_write   = 1'b1;
						r.gen_channel = (mode_q == MODE_GEN1);
						r.gen_word    = it.rx_word;
						mode_q        = MODE_IDLE;
					end
					MODE_I2C: begin
						r.i2c_write   = 1'b1;
						r.i2c_address = it.rx_word[15:8];
						r.i2c_byte    = it.rx_word[7:0];
						mode_q        = MODE_IDLE;
					end
					MODE_PWMA: begin
						tgt_a  = it.rx_word;
						mode_q = MODE_IDLE;
					end
					MODE_PWMB: begin
						tgt_b  = it.rx_word;
						mode_q = MODE_IDLE;
					end
					default: mode_q = MODE_IDLE;
				endcase
			end
			REQ_TICK: begin
				fire  = 1'b0;
				pwm_a = slew_toward(pwm_a, tgt_a, slew_step);
				pwm_b = slew_toward(pwm_b, tgt_b, slew_step);
				if (it.power_lost) begin
					// saturate, so the request fires only once per outage
					if (loss_cnt < LOSS_MAX) begin
						loss_cnt = loss_cnt + 16'd1;
						fire     = (loss_cnt == shutdown_ticks);
					end
				end else begin
					loss_cnt = '0;
				end
				r = quiet_result();
				r.shutdown_req = fire;
			end
			default: r = quiet_result();
		endcase
		expected_results.push_back(r);
	endtask

	task automatic check_field(string name, logic [15:0] expv, logic [15:0] actv);
		if (actv !== expv) begin
			fail_count++;
			$error("%s: expected %0h, got %0h", name, expv, actv);
		end
	endtask

	task automatic compare_result(out_item_t got);
		out_item_t want;
		if (expected_results.size() == 0) begin
			fail_count++;
			$error("result transfer with nothing expected: tx_word %0h", got.tx_word);
			return;
		end
		want = expected_results.pop_front();
		check_field("tx_load", 16'(want.tx_load), 16'(got.tx_load));
		check_field("tx_front", 16'(want.tx_front), 16'(got.tx_front));
		check_field("tx_word", want.tx_word, got.tx_word);
		check_field("gen_write", 16'(want.gen_write), 16'(got.gen_write));
		check_field("gen_channel", 16'(want.gen_channel), 16'(got.gen_channel));
		check_field("gen_word", want.gen_word, got.gen_word);
		check_field("i2c_write", 16'(want.i2c_write), 16'(got.i2c_write));
		check_field("i2c_address", 16'(want.i2c_address), 16'(got.i2c_address));
		check_field("i2c_byte", 16'(want.i2c_byte), 16'(got.i2c_byte));
		check_field("pwm_a_out", want.pwm_a_out, got.pwm_a_out);
		check_field("pwm_b_out", want.pwm_b_out, got.pwm_b_out);
		check_field("shutdown_req", 16'(want.shutdown_req), 16'(got.shutdown_req));
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			slew_step      = SLEW_STEP_RST;
			shutdown_ticks = SHUTDOWN_TICKS_RST;
			mode_q         = MODE_IDLE;
			read_cnt       = '0;
			tgt_a          = '0;
			tgt_b          = '0;
			pwm_a          = '0;
			pwm_b          = '0;
			loss_cnt       = '0;
			expected_results.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					CFG_SLEW_STEP:      slew_step      = cfg_data;
					CFG_SHUTDOWN_TICKS: shutdown_ticks = cfg_data;
					default: ;
				endcase
			end
			if (req_valid && !req_stall)
				predict_bridge(req);
			if (res_valid && !res_stall)
				compare_result(res);
		end
		pending = expected_results.size();
	end

endmodule

// ===== tb/tb_spi_command_bridge_slew_limited.sv =====
`timescale 1ns / 1ps

module tb_spi_command_bridge_slew_limited;

	import spicb_pkg::*;

	localparam int RESET_CYCLES   = 10;
	localparam int HOLD_CYCLES    = 60;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES   = 8;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	in_item_t    req;
	logic        res_valid;
	logic        res_stall;
	out_item_t   res;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [0:0]  cfg_index;
	logic [15:0] cfg_data;

	int fail_count;
	int pending;
	int items_sent   = 0;
	int quiet_cycles = 0;
	bit sender_gaps  = 1'b0;
	bit sink_stalls  = 1'b0;
	bit hold_req     = 1'b0;

	always #6 clk = ~clk;

	spi_command_bridge_slew_limited u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	spicb_bridge_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	function automatic logic [15:0] rand_word();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'hF000;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [15:0] pick_command();
		case ($urandom_range(0, 5))
			0: return CMD_READ_ENC;
			1: return CMD_GEN0;
			2: return CMD_GEN1;
			3: return CMD_I2C;
			4: return CMD_PWMA;
			default: return CMD_PWMB;
		endcase
	endfunction

	function automatic in_item_t make_item(req_type_t kind, logic [15:0] word, logic lost);
		in_item_t it;
		it.req_type   = kind;
		it.rx_word    = word;
		it.enc_a      = rand_word();
		it.enc_b      = rand_word();
		it.enc_c      = rand_word();
		it.power_lost = lost;
		return it;
	endfunction

	// returns right after the accepting edge; the caller's next step owns req_valid
	task automatic send_item(in_item_t it);
		int gap;
		@(negedge clk);
		if (sender_gaps && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 8);
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req       <= it;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		items_sent++;
	endtask

	task automatic send_fall();
		send_item(make_item(REQ_SEL_FALL, rand_word(), 1'($urandom_range(0, 1))));
	endtask

	task automatic send_rise(logic [15:0] word);
		send_item(make_item(REQ_SEL_RISE, word, 1'($urandom_range(0, 1))));
	endtask

	task automatic send_tick(logic lost);
		send_item(make_item(REQ_TICK, rand_word(), lost));
	endtask

	task automatic stop_sending();
		@(negedge clk);
		req_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending != 0) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [15:0] value);
		cfg_index <= idx;
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	// registers change only with the bridge drained
	task automatic configure(logic [15:0] step, logic [15:0] ticks);
		stop_sending();
		wait_drained();
		write_reg(CFG_SLEW_STEP, step);
		write_reg(CFG_SHUTDOWN_TICKS, ticks);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_transaction();
		int          kind;
		int          run;
		bit          lossy;
		logic [15:0] cmd;
		in_item_t    it;
		kind = $urandom_range(0, 9);
		if (kind <= 5) begin
			// well-formed command with random data, sometimes a tick in between
			cmd = pick_command();
			send_fall();
			send_rise(cmd);
			repeat ((cmd == CMD_READ_ENC) ? 3 : 1) begin
				if ($urandom_range(0, 7) == 0)
					send_tick(1'($urandom_range(0, 1)));
				send_fall();
				send_rise(rand_word());
			end
		end else if (kind <= 7) begin
			run   = $urandom_range(1, 6);
			lossy = 1'($urandom_range(0, 1));
			repeat (run)
				send_tick(lossy ? ($urandom_range(0, 7) != 0) : 1'($urandom_range(0, 1)));
		end else begin
			it = make_item(REQ_SEL_FALL, $urandom_range(0, 1) ? rand_word() : pick_command(),
				1'($urandom_range(0, 1)));
			it.req_type = 2'($urandom_range(0, 3));
			send_item(it);
		end
	endtask

	task automatic random_phase(int n);
		int stop_at;
		stop_at = items_sent + n;
		while (items_sent < stop_at) random_transaction();
	endtask

	// result side: random stall bursts, or one long hold-off on request
	initial begin
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				res_stall <= 1'b0;
				hold_req = 1'b0;
			end else if (sink_stalls && $urandom_range(0, 4) == 0) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 8)) @(negedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (res_valid && !res_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("spi_command_bridge_slew_limited: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		in_item_t it;
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_SLEW_STEP;
		cfg_data  = '0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		sender_gaps = 1'b1;
		sink_stalls = 1'b1;

		// every mode and command once, at reset settings
		send_fall();
		it = make_item(REQ_SEL_RISE, CMD_READ_ENC, 1'b0);
		it.enc_a = 16'hF000;
		it.enc_b = 16'hFFFF;
		it.enc_c = 16'h0000;
		send_item(it);
		send_fall();
		repeat (3) send_rise(rand_word());
		send_fall();
		send_rise(CMD_GEN0);
		send_fall();
		send_rise(16'hFFFF);
		send_rise(CMD_GEN1);
		send_fall();
		send_rise(16'h0000);
		send_rise(CMD_I2C);
		send_fall();
		send_rise(16'hA55A);
		send_rise(CMD_PWMA);
		send_fall();
		send_rise(16'hFFFF);
		send_rise(CMD_PWMB);
		send_fall();
		send_rise(16'h1234);
		send_rise(16'h0011);
		it = make_item(REQ_SEL_FALL, 16'hFFFF, 1'b1);
		it.req_type = REQ_RSVD;
		send_item(it);

		// frozen outputs, shutdown on the first lost tick and again after recovery
		configure(16'd0, 16'd1);
		send_tick(1'b1);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b1);
		// full-range step, zero threshold never fires
		configure(16'hFFFF, 16'd0);
		send_tick(1'b1);
		send_tick(1'b1);

		configure(16'd1, 16'd2);
		random_phase(30);

		// long hold-off on the result side while transfers keep coming
		configure(16'd50, 16'd3);
		hold_req    = 1'b1;
		sender_gaps = 1'b0;
		random_phase(25);
		sender_gaps = 1'b1;
		stop_sending();
		wait_drained();
		random_phase(15);

		configure(16'($urandom_range(0, 65535)), 16'($urandom_range(1, 8)));
		random_phase(30);

		configure(16'hFFFF, 16'hFFFF);
		sender_gaps = 1'b0;
		sink_stalls = 1'b0;
		random_phase(35);

		stop_sending();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("spi_command_bridge_slew_limited: match");
		end else begin
			$display("spi_command_bridge_slew_limited: mismatch");
		end
		$finish;
	end

endmodule
